// ----- rtl/rclfr_pkg.sv -----
// Shared types, constants and codes of the RC link frame receiver.
package rclfr_pkg;

  localparam int FRAME_BYTES       = 26;
  localparam int PAYLOAD_FIRST     = 3;
  localparam int TYPE_POS          = 2;
  localparam int CHANNEL_BITS      = 11;
  localparam int CHANNEL_COUNT_DEF = 16;
  localparam int POS_W             = 5;
  localparam int BUF_W             = 18;
  localparam int CNT_W             = 5;
  localparam int CFG_W             = 16;

  localparam logic [7:0]  CRC_POLY          = 8'hD5;
  localparam logic [7:0]  SYNC_ADDRESS_RST  = 8'hC8;
  localparam logic [7:0]  FRAME_TYPE_RST    = 8'h16;
  localparam logic [15:0] TIMEOUT_RST       = 16'd300;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_FRAME_TYPE   = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic KIND_CHANNEL  = 1'b0;
  localparam logic KIND_FAILSAFE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAIL,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic load;
    logic shift;
  } unpack_ctrl_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        failsafe;
    logic        last_of_run;
  } out_t;

endpackage

// ----- rtl/rclfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rclfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 26,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rclfr_crc8.sv -----
// One byte step of the CRC-8 (MSB first) over the frame body.
module rclfr_crc8 (
  input  logic [7:0] acc,
  input  logic [7:0] data,
  output logic [7:0] crc
);
  import rclfr_pkg::*;

  always_comb begin
    logic [7:0] v;
    v = acc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    crc = v;
  end

endmodule

// ----- rtl/rclfr_unpack.sv -----
// Bit buffer that merges payload bytes LSB first and peels off 11-bit channels.
module rclfr_unpack (
  input  logic                    clk,
  input  logic                    rst,
  input  rclfr_pkg::unpack_ctrl_t ctrl,
  input  logic [7:0]              rd_data,
  output logic                    have_ch,
  output logic [10:0]             channel_value
);
  import rclfr_pkg::*;

  logic [BUF_W-1:0] bits;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.start) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= cnt + CNT_W'(8);
    end else if (ctrl.shift) begin
      cnt <= cnt - CNT_W'(CHANNEL_BITS);
    end
  end

  // a load only happens with fewer than 11 bits held, so the byte fits
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bits <= '0;
    end else if (ctrl.load) begin
      bits <= bits | (BUF_W'(rd_data) << cnt);
    end else if (ctrl.shift) begin
      bits <= bits >> CHANNEL_BITS;
    end
  end

  assign have_ch       = cnt >= CNT_W'(CHANNEL_BITS);
  assign channel_value = bits[10:0];

endmodule

// ----- rtl/rc_link_frame_receiver_top.sv -----
// Top level of the RC link frame receiver: framing, CRC, failsafe timer, unpack sequencer.
//
// Items arrive on item_valid/item_ready: a serial byte (opcode byte) or a
// one millisecond tick. Results leave on result_valid/result_ready through
// one output register. Config writes go through cfg_we/cfg_index/cfg_data.
// A byte or tick beat is taken whenever the sequencer is idle;
// CRC is folded in byte by byte, so bytes can follow back to back.
// A tick that trips the timeout yields one failsafe result: item_ready drops
// until the output register is free and takes it.
// The last byte of a good frame starts the unpack walk: each of the 22
// payload bytes costs a frame store read and a merge, and each channel a
// check state and an emit state; item_ready is low during that walk.
// A stalled receiver holds the output register; the walk waits on it at
// each emit, and a new beat is taken only once the walk has handed its last
// result to the output register.
// Reset (rst, synchronous) returns the config registers to their defaults,
// clears the byte position and the timer and sets failsafe. The frame store
// needs no clearing: every byte of a frame is written before it is read.
module rc_link_frame_receiver_top #(
  parameter int CHANNEL_COUNT = rclfr_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  rclfr_pkg::in_t               item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output rclfr_pkg::out_t              result,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [rclfr_pkg::CFG_W-1:0]  cfg_data
);
  import rclfr_pkg::*;

  logic [7:0]       sync_address;
  logic [7:0]       channel_frame_type;
  logic [15:0]      failsafe_timeout_ms;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       crc;
  logic [7:0]       type_byte;
  logic [15:0]      ms_since_good_frame;
  logic             failsafe_flag;
  logic [POS_W-1:0] rd_idx;
  logic [3:0]       ch_idx;
  state_t           state, state_next;

  logic             accept, is_tick, byte_take, last_byte, frame_good, raise;
  logic             slot_free, have_ch, last_ch, rd_issue, emit_fs;
  logic [7:0]       crc_acc, crc_calc, rd_data;
  logic [15:0]      ms_inc;
  logic [10:0]      channel_value;
  logic [POS_W-1:0] rd_addr;
  unpack_ctrl_t     ctrl;

  assign item_ready = state == ST_IDLE;
  assign accept     = item_valid && item_ready;
  assign is_tick    = item.opcode == OP_TICK;
  assign byte_take  = accept && !is_tick &&
                      (byte_position != '0 || item.rx_byte == sync_address);
  assign last_byte  = byte_position == POS_W'(FRAME_BYTES - 1);
  assign crc_acc    = (byte_position == POS_W'(TYPE_POS)) ? 8'h00 : crc;
  assign frame_good = byte_take && last_byte && crc == item.rx_byte &&
                      type_byte == channel_frame_type;
  assign ms_inc     = (ms_since_good_frame == 16'hFFFF) ? ms_since_good_frame
                                                        : ms_since_good_frame + 16'd1;
  assign raise      = accept && is_tick && ms_inc > failsafe_timeout_ms && !failsafe_flag;
  assign slot_free  = !result_valid || result_ready;
  assign last_ch    = ch_idx == 4'(CHANNEL_COUNT - 1);
  assign rd_addr    = rd_idx + POS_W'(PAYLOAD_FIRST);

  rclfr_crc8 u_crc (
    .acc  (crc_acc),
    .data (item.rx_byte),
    .crc  (crc_calc)
  );

  rclfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (byte_take),
    .waddr (byte_position),
    .wdata (item.rx_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rclfr_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .rd_data       (rd_data),
    .have_ch       (have_ch),
    .channel_value (channel_value)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (raise) begin
          state_next = ST_FAIL;
        end else if (frame_good) begin
          state_next = ST_READ;
        end
      end
      ST_FAIL: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = have_ch ? ST_EMIT : ST_LOAD;
      end
      ST_LOAD: begin
        state_next = ST_READ;
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_next = last_ch ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.start = frame_good;
    ctrl.load  = state == ST_LOAD;
    ctrl.shift = state == ST_EMIT && slot_free;
    rd_issue   = state == ST_READ && !have_ch;
    emit_fs    = state == ST_FAIL && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_address        <= SYNC_ADDRESS_RST;
      channel_frame_type  <= FRAME_TYPE_RST;
      failsafe_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_ADDRESS: sync_address        <= cfg_data[7:0];
        CFG_FRAME_TYPE:   channel_frame_type  <= cfg_data[7:0];
        CFG_TIMEOUT:      failsafe_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      ms_since_good_frame <= '0;
      failsafe_flag       <= 1'b1;
      rd_idx              <= '0;
      ch_idx              <= '0;
      result_valid        <= 1'b0;
    end else begin
      if (byte_take) begin
        byte_position <= last_byte ? '0 : byte_position + POS_W'(1);
      end
      if (frame_good) begin
        ms_since_good_frame <= '0;
        failsafe_flag       <= 1'b0;
      end else if (accept && is_tick) begin
        ms_since_good_frame <= ms_inc;
        if (raise) begin
          failsafe_flag <= 1'b1;
        end
      end
      if (ctrl.start) begin
        rd_idx <= '0;
        ch_idx <= '0;
      end else begin
        if (rd_issue) begin
          rd_idx <= rd_idx + POS_W'(1);
        end
        if (ctrl.shift) begin
          ch_idx <= ch_idx + 4'd1;
        end
      end
      if (emit_fs || ctrl.shift) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // body CRC and the type byte ride along with the incoming beats
  always_ff @(posedge clk) begin
    if (byte_take) begin
      crc <= crc_calc;
      if (byte_position == POS_W'(TYPE_POS)) begin
        type_byte <= item.rx_byte;
      end
    end
    if (emit_fs) begin
      result.result_kind   <= KIND_FAILSAFE;
      result.channel_index <= '0;
      result.channel_value <= '0;
      result.failsafe      <= 1'b1;
      result.last_of_run   <= 1'b1;
    end else if (ctrl.shift) begin
      result.result_kind   <= KIND_CHANNEL;
      result.channel_index <= ch_idx;
      result.channel_value <= channel_value;
      result.failsafe      <= 1'b0;
      result.last_of_run   <= last_ch;
    end
  end

endmodule
